[rtl/core/msadpcm_pkg.sv]
// Shared types, codes and constants of the MS ADPCM block decoder.
package msadpcm_pkg;

    // Predictor coefficient table size and the config registers that hold it.
    localparam int COEF_PAIRS = 8;
    localparam int COEF_REGS  = 4;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_BLOCK_BYTES   = 3'd1;
    localparam logic [2:0] REG_COEF_COUNT    = 3'd2;
    localparam logic [2:0] REG_COEF_PAIRS_01 = 3'd3;
    localparam logic [2:0] REG_COEF_PAIRS_23 = 3'd4;
    localparam logic [2:0] REG_COEF_PAIRS_45 = 3'd5;
    localparam logic [2:0] REG_COEF_PAIRS_67 = 3'd6;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;

    // Header word fields.
    localparam logic [1:0] FIELD_DELTA  = 2'd0;
    localparam logic [1:0] FIELD_NEWEST = 2'd1;
    localparam logic [1:0] FIELD_OLDER  = 2'd2;

    // Step delta adaptation factors, indexed by the 4-bit code.
    localparam logic [9:0] ADAPT_TABLE [16] = '{
        10'd230, 10'd230, 10'd230, 10'd230, 10'd307, 10'd409, 10'd512, 10'd614,
        10'd768, 10'd614, 10'd512, 10'd409, 10'd307, 10'd230, 10'd230, 10'd230
    };

    // Kinds of work the front hands to the back.
    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_COEF,
        CMD_WORD,
        CMD_DATA
    } cmd_kind_t;

    // One queued command. The data field holds a coefficient pair, a header
    // word or a data byte depending on the kind.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  status;
        logic        ch;
        logic        stereo;
        logic [1:0]  field;
        logic        emit;
        logic [31:0] data;
    } cmd_t;

endpackage

[rtl/core/ms_adpcm_block_decoder_top.sv]
// Top level of the MS ADPCM block decoder: front, command queue and back.
//
// The input channel (in_valid, in_stall, stream_byte) takes one stream word
// per cycle while the two-entry command queue has room. Header words that
// only hold a low byte cause no result and never reach the queue.
// The output channel (out_valid, out_stall, pcm_sample, channel_id,
// last_of_item, status) gives one sample word per cycle at most; last_of_item
// marks the final result caused by an input word.
// An error result passes through the command queue into the output register,
// a seed result through the S_SEED state; a data word gives its first sample
// after the S_MUL and S_FIN states and its second after a further S_MUL/S_FIN.
// In the back a data word is dispatched and then runs the product-sum (S_MUL)
// and finish (S_FIN) stages for each nibble, high nibble first.
// The final header word of a block emits 2 (mono) or 4 (stereo) seed words,
// one per cycle unless the output stalls; other header words give no result.
// Reset (rst_n low, asynchronous) restores the register defaults, clears all
// channel state and starts at the beginning of a block.
// When the receiver stalls, the output word holds, the back waits, and the
// queue fills; in_stall rises once the queue is full.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// in any cycle and belong in idle periods.
module ms_adpcm_block_decoder_top
    import msadpcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         stream_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pcm_sample,
    output logic               channel_id,
    output logic               last_of_item,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Classification of incoming words.
    msadpcm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Decoupling queue.
    msadpcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Decoding and result delivery.
    msadpcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pcm_sample   (pcm_sample),
        .channel_id   (channel_id),
        .last_of_item (last_of_item),
        .status       (status)
    );

endmodule

[rtl/core/msadpcm_front.sv]
// Front part: configuration registers, block position tracking and byte classification.
module msadpcm_front
    import msadpcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [1:0]  chan_count_reg;
    logic [15:0] block_bytes_reg;
    logic [3:0]  coef_count_reg;
    logic [63:0] coef_reg [COEF_REGS];

    logic [15:0] pos_reg;
    logic        skip_reg;
    logic [7:0]  low_reg;

    logic        accept;
    logic        stereo;
    logic [4:0]  hdr_len;
    logic [1:0]  nch;
    logic        blk_end;
    logic [3:0]  valid_pairs;
    logic [3:0]  hdr_off;
    logic [2:0]  hdr_k;
    logic [2:0]  pair_idx;
    logic [31:0] pair_word;
    logic        has_cmd;
    logic        set_skip;
    logic        hold_low;
    cmd_t        cmd;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign push      = accept && has_cmd;
    assign push_cmd  = cmd;

    // Block geometry from the current register values.
    assign stereo      = (chan_count_reg == 2'd2);
    assign hdr_len     = stereo ? 5'd14 : 5'd7;
    assign nch         = stereo ? 2'd2 : 2'd1;
    assign blk_end     = ({1'b0, pos_reg} + 17'd1) >= {1'b0, block_bytes_reg};
    assign valid_pairs = (coef_count_reg < 4'(COEF_PAIRS)) ? coef_count_reg : 4'(COEF_PAIRS);
    assign hdr_off     = pos_reg[3:0] - {2'b00, nch};
    assign hdr_k       = hdr_off[3:1];
    assign pair_idx    = stream_byte[2:0];
    assign pair_word   = pair_idx[0] ? coef_reg[pair_idx[2:1]][63:32]
                                     : coef_reg[pair_idx[2:1]][31:0];

    // Classify the incoming word by its place in the block.
    always_comb
    begin
        has_cmd    = 1'b0;
        set_skip   = 1'b0;
        hold_low   = 1'b0;
        cmd.kind   = CMD_DATA;
        cmd.status = STATUS_OK;
        cmd.ch     = 1'b0;
        cmd.stereo = stereo;
        cmd.field  = FIELD_DELTA;
        cmd.emit   = 1'b0;
        cmd.data   = {24'd0, stream_byte};
        if (!skip_reg)
        begin
            priority if (pos_reg == 16'd0 && block_bytes_reg < 16'(hdr_len))
            begin
                has_cmd    = 1'b1;
                set_skip   = 1'b1;
                cmd.kind   = CMD_ERR;
                cmd.status = STATUS_SHORT;
            end
            else if (pos_reg < 16'(nch))
            begin
                has_cmd = 1'b1;
                cmd.ch  = pos_reg[0];
                if (stream_byte >= {4'd0, valid_pairs})
                begin
                    set_skip   = 1'b1;
                    cmd.kind   = CMD_ERR;
                    cmd.status = STATUS_BAD_INDEX;
                end
                else
                begin
                    cmd.kind = CMD_COEF;
                    cmd.data = pair_word;
                end
            end
            else if (pos_reg < 16'(hdr_len))
            begin
                if (!hdr_off[0])
                begin
                    hold_low = 1'b1;
                end
                else
                begin
                    has_cmd   = 1'b1;
                    cmd.kind  = CMD_WORD;
                    cmd.data  = {16'd0, stream_byte, low_reg};
                    cmd.field = stereo ? hdr_k[2:1] : hdr_k[1:0];
                    cmd.ch    = stereo & hdr_k[0];
                    cmd.emit  = (cmd.field == FIELD_OLDER) && (cmd.ch == stereo);
                end
            end
            else
            begin
                has_cmd = 1'b1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg  <= 2'd1;
            block_bytes_reg <= 16'd256;
            coef_count_reg  <= 4'd7;
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= 64'd0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: chan_count_reg  <= cfg_data[1:0];
                REG_BLOCK_BYTES:   block_bytes_reg <= cfg_data[15:0];
                REG_COEF_COUNT:    coef_count_reg  <= cfg_data[3:0];
                REG_COEF_PAIRS_01: coef_reg[0]     <= cfg_data;
                REG_COEF_PAIRS_23: coef_reg[1]     <= cfg_data;
                REG_COEF_PAIRS_45: coef_reg[2]     <= cfg_data;
                REG_COEF_PAIRS_67: coef_reg[3]     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Block position, skip flag and the held low header byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 16'd0;
            skip_reg <= 1'b0;
            low_reg  <= 8'd0;
        end
        else if (accept)
        begin
            if (hold_low)
            begin
                low_reg <= stream_byte;
            end
            if (blk_end)
            begin
                pos_reg  <= 16'd0;
                skip_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 16'd1;
                if (set_skip)
                begin
                    skip_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/msadpcm_queue.sv]
// Short command queue between the front and the back of the decoder.
module msadpcm_queue
    import msadpcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/msadpcm_back.sv]
// Back part: channel state, nibble decoding, seed emission and the output register.
module msadpcm_back
    import msadpcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  cmd_t               head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pcm_sample,
    output logic               channel_id,
    output logic               last_of_item,
    output logic [1:0]         status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FIN,
        S_SEED
    } state_t;

    state_t             state_reg;
    logic               nib_sel_reg;
    logic [1:0]         seed_idx_reg;
    logic signed [32:0] prod_sum_reg;

    logic signed [15:0] coef1_reg  [2];
    logic signed [15:0] coef2_reg  [2];
    logic signed [15:0] delta_reg  [2];
    logic signed [15:0] newest_reg [2];
    logic signed [15:0] older_reg  [2];

    logic               out_valid_reg;
    logic signed [15:0] pcm_reg;
    logic               ch_reg;
    logic               last_reg;
    logic [1:0]         status_reg;

    logic               out_free;
    logic [3:0]         nib_code;
    logic               dec_ch;
    logic signed [31:0] prod1;
    logic signed [31:0] prod2;
    logic signed [32:0] prod_sum;
    logic signed [24:0] pred_base;
    logic signed [4:0]  code_s;
    logic signed [20:0] step_term;
    logic signed [25:0] pred;
    logic signed [15:0] sample_clamped;
    logic signed [10:0] adapt_s;
    logic signed [26:0] adapt_prod;
    logic signed [18:0] delta_new;
    logic signed [15:0] delta_clamped;
    logic               seed_ch;
    logic               seed_newer;
    logic               seed_last;

    assign out_valid    = out_valid_reg;
    assign pcm_sample   = pcm_reg;
    assign channel_id   = ch_reg;
    assign last_of_item = last_reg;
    assign status       = status_reg;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Prediction products for the current nibble.
    assign nib_code = nib_sel_reg ? head_cmd.data[3:0] : head_cmd.data[7:4];
    assign dec_ch   = nib_sel_reg & head_cmd.stereo;
    assign prod1    = newest_reg[dec_ch] * coef1_reg[dec_ch];
    assign prod2    = older_reg[dec_ch] * coef2_reg[dec_ch];
    assign prod_sum = 33'(prod1) + 33'(prod2);

    // Prediction finish: floor of the product sum over 256 plus code times delta.
    assign pred_base = $signed(prod_sum_reg[32:8]);
    assign code_s    = $signed({nib_code[3], nib_code});
    assign step_term = code_s * delta_reg[dec_ch];
    assign pred      = 26'(pred_base) + 26'(step_term);

    always_comb
    begin
        priority if (pred < -26'sd32768)
        begin
            sample_clamped = -16'sd32768;
        end
        else if (pred > 26'sd32767)
        begin
            sample_clamped = 16'sd32767;
        end
        else
        begin
            sample_clamped = pred[15:0];
        end
    end

    // Delta adaptation, floored, held at a minimum of 16 and saturated.
    assign adapt_s    = $signed({1'b0, ADAPT_TABLE[nib_code]});
    assign adapt_prod = adapt_s * delta_reg[dec_ch];
    assign delta_new  = $signed(adapt_prod[26:8]);

    always_comb
    begin
        priority if (delta_new < 19'sd16)
        begin
            delta_clamped = 16'sd16;
        end
        else if (delta_new > 19'sd32767)
        begin
            delta_clamped = 16'sd32767;
        end
        else
        begin
            delta_clamped = delta_new[15:0];
        end
    end

    // Seed order: older samples first, left before right.
    assign seed_ch    = head_cmd.stereo & seed_idx_reg[0];
    assign seed_newer = head_cmd.stereo ? seed_idx_reg[1] : seed_idx_reg[0];
    assign seed_last  = (seed_idx_reg == (head_cmd.stereo ? 2'd3 : 2'd1));

    // A command leaves the queue when its last step completes.
    always_comb
    begin
        pop = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_cmd.kind)
                        CMD_ERR:  pop = out_free;
                        CMD_COEF: pop = 1'b1;
                        CMD_WORD: pop = !head_cmd.emit;
                        CMD_DATA: pop = 1'b0;
                    endcase
                end
            end
            S_MUL:  pop = 1'b0;
            S_FIN:  pop = out_free && nib_sel_reg;
            S_SEED: pop = out_free && seed_last;
        endcase
    end

    // Sequencer, channel state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nib_sel_reg   <= 1'b0;
            seed_idx_reg  <= 2'd0;
            prod_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
            pcm_reg       <= '0;
            ch_reg        <= 1'b0;
            last_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            for (int i = 0; i < 2; i++)
            begin
                coef1_reg[i]  <= '0;
                coef2_reg[i]  <= '0;
                delta_reg[i]  <= '0;
                newest_reg[i] <= '0;
                older_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        unique case (head_cmd.kind)
                            CMD_ERR:
                            begin
                                if (out_free)
                                begin
                                    out_valid_reg <= 1'b1;
                                    pcm_reg       <= '0;
                                    ch_reg        <= head_cmd.ch;
                                    last_reg      <= 1'b1;
                                    status_reg    <= head_cmd.status;
                                end
                            end
                            CMD_COEF:
                            begin
                                coef1_reg[head_cmd.ch] <= head_cmd.data[15:0];
                                coef2_reg[head_cmd.ch] <= head_cmd.data[31:16];
                            end
                            CMD_WORD:
                            begin
                                unique case (head_cmd.field)
                                    FIELD_DELTA:  delta_reg[head_cmd.ch]  <= head_cmd.data[15:0];
                                    FIELD_NEWEST: newest_reg[head_cmd.ch] <= head_cmd.data[15:0];
                                    FIELD_OLDER:  older_reg[head_cmd.ch]  <= head_cmd.data[15:0];
                                    default:      ;
                                endcase
                                if (head_cmd.emit)
                                begin
                                    seed_idx_reg <= 2'd0;
                                    state_reg    <= S_SEED;
                                end
                            end
                            CMD_DATA:
                            begin
                                nib_sel_reg <= 1'b0;
                                state_reg   <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    prod_sum_reg <= prod_sum;
                    state_reg    <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        older_reg[dec_ch]  <= newest_reg[dec_ch];
                        newest_reg[dec_ch] <= sample_clamped;
                        delta_reg[dec_ch]  <= delta_clamped;
                        out_valid_reg      <= 1'b1;
                        pcm_reg            <= sample_clamped;
                        ch_reg             <= dec_ch;
                        last_reg           <= nib_sel_reg;
                        status_reg         <= STATUS_OK;
                        if (nib_sel_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            nib_sel_reg <= 1'b1;
                            state_reg   <= S_MUL;
                        end
                    end
                end
                S_SEED:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pcm_reg       <= seed_newer ? newest_reg[seed_ch] : older_reg[seed_ch];
                        ch_reg        <= seed_ch;
                        last_reg      <= seed_last;
                        status_reg    <= STATUS_OK;
                        if (seed_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            seed_idx_reg <= seed_idx_reg + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule
